/* hw/rtl/abpf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abpf_pkg
// Shared types and constants of the affine background pixel fetch unit.
// ----------------------------------------------------------------------------
package abpf_pkg;

  // video memory geometry
  localparam int unsigned VideoWords = 32768;
  localparam int unsigned VramAw     = 15;
  localparam int unsigned VramDw     = 16;

  // extended layer: color bit 7 becomes the priority bit
  localparam logic ExtendedLayer = 1'b0;

  // item commands
  localparam logic [1:0] CmdWrite     = 2'd0;
  localparam logic [1:0] CmdLineStart = 2'd1;
  localparam logic [1:0] CmdPixel     = 2'd2;

  // configuration register indexes
  localparam logic [2:0] RegMatrixA = 3'd0;
  localparam logic [2:0] RegMatrixB = 3'd1;
  localparam logic [2:0] RegMatrixC = 3'd2;
  localparam logic [2:0] RegMatrixD = 3'd3;
  localparam logic [2:0] RegCenterX = 3'd4;
  localparam logic [2:0] RegCenterY = 3'd5;
  localparam logic [2:0] RegRepeat  = 3'd6;
  localparam logic [2:0] RegFlip    = 3'd7;

  // repeat modes that are not wrap
  localparam logic [1:0] RepeatTransparent = 2'd2;
  localparam logic [1:0] RepeatTileZero    = 2'd3;

  typedef struct packed {
    logic signed [15:0] matrix_a;
    logic signed [15:0] matrix_b;
    logic signed [15:0] matrix_c;
    logic signed [15:0] matrix_d;
    logic signed [12:0] center_x;
    logic signed [12:0] center_y;
    logic [1:0]         repeat_mode;
    logic [1:0]         flip_control;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic commit;
  } ls_ctrl_t;

  typedef struct packed {
    logic [7:0]         line_number;
    logic signed [12:0] scroll_h;
    logic signed [12:0] scroll_v;
  } ls_op_t;

  typedef struct packed {
    logic              we;
    logic [VramAw-1:0] waddr;
    logic [VramDw-1:0] wdata;
    logic              re_a;
    logic [VramAw-1:0] addr_a;
    logic              re_b;
    logic [VramAw-1:0] addr_b;
  } vram_req_t;

endpackage

/* hw/rtl/abpf_vram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abpf_vram
// Video memory: one write port and two registered read ports (tile, color).
// ----------------------------------------------------------------------------
module abpf_vram (
  input  logic                       clk_i,
  input  abpf_pkg::vram_req_t        req_i,
  output logic [abpf_pkg::VramDw-1:0] rdata_a_o,
  output logic [abpf_pkg::VramDw-1:0] rdata_b_o
);

  logic [abpf_pkg::VramDw-1:0] mem_q [abpf_pkg::VideoWords];
  logic [abpf_pkg::VramDw-1:0] rdata_a_q;
  logic [abpf_pkg::VramDw-1:0] rdata_b_q;

  // reads return the old word when the same entry is written in that cycle
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re_a) begin
      rdata_a_q <= mem_q[req_i.addr_a];
    end
    if (req_i.re_b) begin
      rdata_b_q <= mem_q[req_i.addr_b];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* hw/rtl/abpf_line_setup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abpf_line_setup
// Line start coordinates: six masked products summed over a shared
// multiplier, committed to the line start registers when the item retires.
// ----------------------------------------------------------------------------
module abpf_line_setup (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  abpf_pkg::cfg_t     cfg_i,
  input  abpf_pkg::ls_ctrl_t ctrl_i,
  input  abpf_pkg::ls_op_t   op_i,
  output logic               done_o,
  output logic [31:0]        line_start_x_o,
  output logic [31:0]        line_start_y_o
);

  localparam logic [2:0] StepFirstAcc = 3'd1;
  localparam logic [2:0] StepFirstY   = 3'd4;
  localparam logic [2:0] StepLast     = 3'd6;
  localparam logic [2:0] StepDone     = 3'd7;

  logic               run_q, run_d;
  logic [2:0]         cnt_q, cnt_d;
  logic [31:0]        acc_x_q, acc_x_d;
  logic [31:0]        acc_y_q, acc_y_d;
  logic [31:0]        lsx_q, lsx_d;
  logic [31:0]        lsy_q, lsy_d;
  logic signed [26:0] mul_q, mul_d;

  logic [7:0]         y8;
  logic [13:0]        diff_h;
  logic [13:0]        diff_v;
  logic signed [10:0] dx;
  logic signed [10:0] dy;
  logic signed [10:0] ly;
  logic signed [15:0] op_m;
  logic signed [10:0] op_v;
  logic [31:0]        masked;
  logic               acc_en;

  always_comb begin
    y8     = cfg_i.flip_control[1] ? ~op_i.line_number : op_i.line_number;
    diff_h = {op_i.scroll_h[12], op_i.scroll_h} - {cfg_i.center_x[12], cfg_i.center_x};
    diff_v = {op_i.scroll_v[12], op_i.scroll_v} - {cfg_i.center_y[12], cfg_i.center_y};
    // 10-bit clip: bit 13 of the difference picks the fill
    dx     = {diff_h[13], diff_h[9:0]};
    dy     = {diff_v[13], diff_v[9:0]};
    ly     = $signed({3'b000, y8});

    case (cnt_q)
      3'd0:    begin op_m = cfg_i.matrix_a; op_v = dx; end
      3'd1:    begin op_m = cfg_i.matrix_b; op_v = dy; end
      3'd2:    begin op_m = cfg_i.matrix_b; op_v = ly; end
      3'd3:    begin op_m = cfg_i.matrix_c; op_v = dx; end
      3'd4:    begin op_m = cfg_i.matrix_d; op_v = dy; end
      3'd5:    begin op_m = cfg_i.matrix_d; op_v = ly; end
      default: begin op_m = '0;             op_v = '0; end
    endcase

    mul_d  = op_m * op_v;
    masked = {{5{mul_q[26]}}, mul_q[26:6], 6'b000000};
    acc_en = run_q && (cnt_q >= StepFirstAcc) && (cnt_q <= StepLast);

    run_d   = run_q;
    cnt_d   = cnt_q;
    acc_x_d = acc_x_q;
    acc_y_d = acc_y_q;
    lsx_d   = lsx_q;
    lsy_d   = lsy_q;

    if (acc_en) begin
      if (cnt_q < StepFirstY) begin
        acc_x_d = acc_x_q + masked;
      end else begin
        acc_y_d = acc_y_q + masked;
      end
    end
    if (run_q && cnt_q != StepDone) begin
      cnt_d = cnt_q + 3'd1;
    end
    if (ctrl_i.commit) begin
      lsx_d = acc_x_q;
      lsy_d = acc_y_q;
      run_d = 1'b0;
    end
    if (ctrl_i.start) begin
      run_d   = 1'b1;
      cnt_d   = '0;
      acc_x_d = {{11{cfg_i.center_x[12]}}, cfg_i.center_x, 8'd0};
      acc_y_d = {{11{cfg_i.center_y[12]}}, cfg_i.center_y, 8'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
      lsx_q <= '0;
      lsy_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
      lsx_q <= lsx_d;
      lsy_q <= lsy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_x_q <= acc_x_d;
    acc_y_q <= acc_y_d;
    mul_q   <= mul_d;
  end

  assign done_o         = run_q && (cnt_q == StepDone);
  assign line_start_x_o = lsx_q;
  assign line_start_y_o = lsy_q;

endmodule

/* hw/rtl/affine_background_pixel_fetch_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_background_pixel_fetch_unit
// Mode-7 style affine background: video memory load, line setup and a
// pixel fetch pipeline with tile and color reads from one video memory.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid_i / in_stall_o) carries write, line start and
//   pixel items; the output channel (out_valid_o / out_stall_i) gives one
//   beat per pixel item. Configuration goes in on cfg_valid_i / cfg_ready_o
//   while the block is idle; the port is always ready.
//   Writes and pixels enter one per cycle while in_stall_o is low. After
//   its acceptance, a pixel passes multiply, coordinate add and tile read,
//   color read and output register before its beat is valid. A line start
//   holds the input while its six products go one per cycle through a single
//   multiplier; the new start coordinates take effect when it retires.
//   Video memory has two read ports, so tile and color reads of successive
//   pixels overlap; unstalled, the pipeline sustains one pixel per cycle.
//   When the receiver stalls, the output register holds its beat and the
//   stages behind it fill up before in_stall_o rises.
//   Reset clears configuration and start coordinates; video memory content
//   stays undefined until written and gets no clearing pass.
// ----------------------------------------------------------------------------
module affine_background_pixel_fetch_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  // input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  logic [14:0]        mem_address_i,
  input  logic [15:0]        mem_data_i,
  input  logic [7:0]         line_number_i,
  input  logic signed [12:0] scroll_h_i,
  input  logic signed [12:0] scroll_v_i,
  input  logic [7:0]         pixel_x_i,
  // results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         screen_x_o,
  output logic [7:0]         color_index_o,
  output logic               priority_select_o,
  output logic               transparent_o
);

  // configuration registers
  abpf_pkg::cfg_t cfg_q, cfg_d;
  logic           cfg_accept;

  assign cfg_ready_o = 1'b1;
  assign cfg_accept  = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_accept) begin
      unique case (cfg_index_i)
        abpf_pkg::RegMatrixA: cfg_d.matrix_a     = cfg_data_i;
        abpf_pkg::RegMatrixB: cfg_d.matrix_b     = cfg_data_i;
        abpf_pkg::RegMatrixC: cfg_d.matrix_c     = cfg_data_i;
        abpf_pkg::RegMatrixD: cfg_d.matrix_d     = cfg_data_i;
        abpf_pkg::RegCenterX: cfg_d.center_x     = cfg_data_i[12:0];
        abpf_pkg::RegCenterY: cfg_d.center_y     = cfg_data_i[12:0];
        abpf_pkg::RegRepeat:  cfg_d.repeat_mode  = cfg_data_i[1:0];
        abpf_pkg::RegFlip:    cfg_d.flip_control = cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // pipeline registers
  logic               v1_q, v2_q, v3_q, v4_q, vo_q;
  logic [1:0]         cmd1_q;
  logic [14:0]        addr1_q, addr2_q;
  logic [15:0]        data1_q, data2_q;
  logic [7:0]         line1_q;
  logic signed [12:0] hofs1_q, vofs1_q;
  logic [7:0]         x1_q, x2_q, x3_q, x4_q;
  logic               pix2_q;
  logic signed [24:0] prod_ax2_q, prod_cx2_q;
  logic [2:0]         fx3_q, fy3_q;
  logic               outside3_q;
  logic               blank4_q;
  logic [7:0]         screen_x_q;
  logic [7:0]         color_q;
  logic               prio_q;

  // handshake and stage advance
  logic in_accept;
  logic leave1, leave2, leave3, leave4;
  logic take1, take2, take3, take4;
  logic s1_ls, s1_pass;
  logic ls_done;

  always_comb begin
    s1_ls   = cmd1_q == abpf_pkg::CmdLineStart;
    s1_pass = (cmd1_q == abpf_pkg::CmdWrite) || (cmd1_q == abpf_pkg::CmdPixel);
    leave4  = v4_q && (!vo_q || !out_stall_i);
    take4   = !v4_q || leave4;
    leave3  = v3_q && take4;
    take3   = !v3_q || leave3;
    // a write waits until an older pixel has read its color byte
    leave2  = v2_q && take3;
    take2   = !v2_q || leave2;
    // a line start retires only once stage 2 is free or moving on, so no
    // older pixel reads the new start coordinates
    if (s1_ls) begin
      leave1 = v1_q && ls_done && take2;
    end else if (s1_pass) begin
      leave1 = v1_q && take2;
    end else begin
      leave1 = v1_q;
    end
    take1 = !v1_q || leave1;
  end

  assign in_stall_o = !take1;
  assign in_accept  = in_valid_i && !in_stall_o;

  // line setup
  abpf_pkg::ls_ctrl_t ls_ctrl;
  abpf_pkg::ls_op_t   ls_op;
  logic [31:0]        ls_x, ls_y;

  assign ls_ctrl.start     = in_accept && (command_i == abpf_pkg::CmdLineStart);
  assign ls_ctrl.commit    = leave1 && s1_ls;
  assign ls_op.line_number = line1_q;
  assign ls_op.scroll_h    = hofs1_q;
  assign ls_op.scroll_v    = vofs1_q;

  abpf_line_setup u_line_setup (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .ctrl_i         (ls_ctrl),
    .op_i           (ls_op),
    .done_o         (ls_done),
    .line_start_x_o (ls_x),
    .line_start_y_o (ls_y)
  );

  // stage 1: column products
  logic signed [24:0] prod_ax, prod_cx;

  assign prod_ax = cfg_q.matrix_a * $signed({1'b0, x1_q});
  assign prod_cx = cfg_q.matrix_c * $signed({1'b0, x1_q});

  // stage 2: map coordinates, tile read or memory write
  logic [31:0] sum_x, sum_y;
  logic [23:0] px, py;
  logic        outside;

  always_comb begin
    sum_x   = ls_x + {{7{prod_ax2_q[24]}}, prod_ax2_q};
    sum_y   = ls_y + {{7{prod_cx2_q[24]}}, prod_cx2_q};
    px      = sum_x[31:8];
    py      = sum_y[31:8];
    outside = (|px[23:10]) || (|py[23:10]);
  end

  // stage 3: color address
  logic [15:0] rdata_a, rdata_b;
  logic [7:0]  tile;

  assign tile = (cfg_q.repeat_mode == abpf_pkg::RepeatTileZero && outside3_q) ?
                8'd0 : rdata_a[7:0];

  abpf_pkg::vram_req_t vram_req;

  assign vram_req.we     = leave2 && !pix2_q;
  assign vram_req.waddr  = addr2_q;
  assign vram_req.wdata  = data2_q;
  assign vram_req.re_a   = leave2 && pix2_q;
  assign vram_req.addr_a = {1'b0, py[9:3], px[9:3]};
  assign vram_req.re_b   = leave3;
  assign vram_req.addr_b = {1'b0, tile, fy3_q, fx3_q};

  abpf_vram u_vram (
    .clk_i     (clk_i),
    .req_i     (vram_req),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // stage 4: result
  logic [7:0] color8;
  logic [7:0] color_d;
  logic       prio_d;

  always_comb begin
    color8 = blank4_q ? 8'd0 : rdata_b[15:8];
    if (abpf_pkg::ExtendedLayer) begin
      prio_d  = color8[7];
      color_d = {1'b0, color8[6:0]};
    end else begin
      prio_d  = 1'b0;
      color_d = color8;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      vo_q  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      if (take1) begin
        v1_q <= in_valid_i;
      end
      if (take2) begin
        v2_q <= leave1 && s1_pass;
      end
      if (take3) begin
        v3_q <= leave2 && pix2_q;
      end
      if (take4) begin
        v4_q <= leave3;
      end
      if (leave4) begin
        vo_q <= 1'b1;
      end else if (!out_stall_i) begin
        vo_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd1_q  <= command_i;
      addr1_q <= mem_address_i;
      data1_q <= mem_data_i;
      line1_q <= line_number_i;
      hofs1_q <= scroll_h_i;
      vofs1_q <= scroll_v_i;
      x1_q    <= pixel_x_i;
    end
    if (take2 && leave1) begin
      pix2_q     <= cmd1_q == abpf_pkg::CmdPixel;
      addr2_q    <= addr1_q;
      data2_q    <= data1_q;
      x2_q       <= x1_q;
      prod_ax2_q <= prod_ax;
      prod_cx2_q <= prod_cx;
    end
    if (vram_req.re_a) begin
      fx3_q      <= px[2:0];
      fy3_q      <= py[2:0];
      outside3_q <= outside;
      x3_q       <= x2_q;
    end
    if (leave3) begin
      blank4_q <= (cfg_q.repeat_mode == abpf_pkg::RepeatTransparent) && outside3_q;
      x4_q     <= x3_q;
    end
    if (leave4) begin
      screen_x_q <= cfg_q.flip_control[0] ? ~x4_q : x4_q;
      color_q    <= color_d;
      prio_q     <= prio_d;
    end
  end

  assign out_valid_o       = vo_q;
  assign screen_x_o        = screen_x_q;
  assign color_index_o     = color_q;
  assign priority_select_o = prio_q;
  assign transparent_o     = color_q == 8'd0;

`ifndef NO_ASSERTIONS
  // an unfinished line setup keeps the input closed
  a_ls_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && s1_ls && !ls_done) |-> in_stall_o)
    else $error("line start retired before its products were summed");

  // start coordinates change only when a line start retires
  a_coord_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ls_ctrl.commit |=> ($stable(ls_x) && $stable(ls_y)))
    else $error("start coordinates changed without a line start commit");

  // the tile stage either writes or reads, never both
  a_port_a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(vram_req.we && vram_req.re_a))
    else $error("video memory write and tile read from one stage");

  // color reads only follow a tile read of a pixel in flight
  a_color_after_tile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vram_req.re_b |-> v3_q)
    else $error("color read without a pixel in the color stage");
`endif

endmodule
